// ===== rtl/ptcd_pkg.sv =====
// Shared types and constants for the pulse timing code decoder.
// No dependencies; used by every module in rtl/.
package ptcd_pkg;

    localparam int DUR_W   = 16;
    localparam int FC_W    = 7;
    localparam int SUM_W   = 19;
    localparam int MSUM_W  = 10;
    localparam int IDX_W   = 3;
    localparam int CFGI_W  = 4;
    localparam int CFGD_W  = 64;

    // register indexes on the configuration port
    localparam logic [CFGI_W-1:0] REG_BASE_TIME = 4'd0;
    localparam logic [CFGI_W-1:0] REG_TOLERANCE = 4'd1;
    localparam logic [CFGI_W-1:0] REG_MIN_FRAME = 4'd2;
    localparam logic [CFGI_W-1:0] REG_MAX_FRAME = 4'd3;
    localparam logic [CFGI_W-1:0] REG_KINDS     = 4'd4;
    localparam logic [CFGI_W-1:0] REG_MULT_A    = 4'd5;
    localparam logic [CFGI_W-1:0] REG_MULT_B    = 4'd6;
    localparam logic [CFGI_W-1:0] REG_MULT_C    = 4'd7;

    // register reset values
    localparam logic [15:0] RST_BASE_TIME = 16'd560;
    localparam logic [6:0]  RST_TOLERANCE = 7'd25;
    localparam logic [6:0]  RST_MIN_FRAME = 7'd1;
    localparam logic [6:0]  RST_MAX_FRAME = 7'd64;

    // kind bits
    localparam int KB_START = 0;
    localparam int KB_DATA  = 1;
    localparam int KB_END   = 2;
    localparam logic [2:0] KIND_END_ONLY = 3'b100;

    // event codes
    localparam logic [1:0] EV_ADD     = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_SHORT   = 2'd2;
    localparam logic [1:0] EV_ABANDON = 2'd3;

    localparam logic [6:0] PCT_SCALE = 7'd100;

    typedef struct packed {
        logic             valid;
        logic [DUR_W-1:0] dur;
        logic             hit_any;
    } ptcd_hand_t;

    typedef struct packed {
        logic              complete;
        logic              retry;
        logic [2:0]        kind;
        logic [IDX_W-1:0]  idx;
        logic [SUM_W-1:0]  sum;
        logic [MSUM_W-1:0] msum;
    } ptcd_status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_NOM,
        PH_CMP
    } cell_phase_t;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_RUN,
        CT_DIV
    } ctrl_state_t;

endpackage

// ===== rtl/pulse_timing_code_decoder_core.sv =====
// Each code cell works in steps (multiply nominal, window compare, hand-on to the next cell),
// so an item walks the chain cell by cell, stopping early when a code completes.
// A completed start code then runs the bit-serial base divider; a start retry re-runs its cell.
// Throughput: one item per walk; the next is taken once chain, divider and pending slot are idle.
// A result goes through a pending slot into the output register; one more may wait in the slot.
// Reset (rst_n, async low): registers to defaults, all codes alive, frame empty.
module pulse_timing_code_decoder_core #(
    parameter int NUM_CODES      = 6,
    parameter int TIMES_PER_CODE = 4,
    parameter int MAX_FRAME      = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // duration items in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] pulse_duration,
    // decode events out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [2:0]  code_index,
    output logic [6:0]  frame_length
);

    ptcd_pkg::ptcd_hand_t   hand_in  [NUM_CODES];
    ptcd_pkg::ptcd_hand_t   hand_out [NUM_CODES];
    ptcd_pkg::ptcd_status_t cell_st  [NUM_CODES];
    ptcd_pkg::ptcd_status_t status;

    logic          clr;
    logic [6:0]    frame_count;
    logic [15:0]   active_base;
    logic [6:0]    tolerance_pct;
    logic [17:0]   code_kinds;
    logic [191:0]  mult_words;

    // an accepted item enters cell 0 with no hit recorded yet
    assign hand_in[0].valid   = in_valid && !in_stall;
    assign hand_in[0].dur     = pulse_duration;
    assign hand_in[0].hit_any = 1'b0;

    // only one cell compares in any cycle, so the status words are simply OR'd
    always_comb
    begin
        status = '0;
        for (int k = 0; k < NUM_CODES; k++)
            status = status | cell_st[k];
    end

    for (genvar k = 0; k < NUM_CODES; k++)
    begin : g_cell
        if (k > 0)
        begin : g_link
            assign hand_in[k] = hand_out[k-1];
        end
        // code k owns byte slots 0..3 of 32-bit word k across the multiple registers
        ptcd_cell #(
            .TIMES_PER_CODE (TIMES_PER_CODE),
            .IDX            (k)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .hand_in       (hand_in[k]),
            .clr           (clr),
            .frame_count   (frame_count),
            .active_base   (active_base),
            .tolerance_pct (tolerance_pct),
            .kind          (code_kinds[3*k +: 3]),
            .mults         (mult_words[32*k +: 8*TIMES_PER_CODE]),
            .hand_out      (hand_out[k]),
            .status        (cell_st[k])
        );
    end

    ptcd_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .status        (status),
        .last_hand     (hand_out[NUM_CODES-1]),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .code_index    (code_index),
        .frame_length  (frame_length),
        .clr           (clr),
        .frame_count   (frame_count),
        .active_base   (active_base),
        .tolerance_pct (tolerance_pct),
        .code_kinds    (code_kinds),
        .mult_words    (mult_words)
    );

endmodule

// ===== rtl/ptcd_cell.sv =====
// One code cell: progress, alive flag and duration sum of one code.
// Depends on ptcd_pkg.
module ptcd_cell #(
    parameter int TIMES_PER_CODE = 4,
    parameter int IDX            = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ptcd_pkg::ptcd_hand_t      hand_in,
    input  logic                      clr,
    input  logic [6:0]                frame_count,
    input  logic [15:0]               active_base,
    input  logic [6:0]                tolerance_pct,
    input  logic [2:0]                kind,
    input  logic [8*TIMES_PER_CODE-1:0] mults,
    output ptcd_pkg::ptcd_hand_t      hand_out,
    output ptcd_pkg::ptcd_status_t    status
);

    ptcd_pkg::cell_phase_t phase_reg, phase_next;
    logic        alive_reg;
    logic [2:0]  prog_reg;
    logic [18:0] sum_reg;
    logic [15:0] dur_reg;
    logic        any_reg;
    logic [23:0] nom_reg;
    logic        hand_valid_reg;
    logic [15:0] hand_dur_reg;
    logic        hand_any_reg;

    logic [2:0]  len;
    logic [9:0]  msum;
    logic [7:0]  cur_mult;
    logic        stop;
    logic [23:0] diff;
    logic [30:0] lhs, rhs;
    logic        cmp, start_ok, chk, hit, retry, complete;

    always_comb
    begin
        len      = 3'd0;
        msum     = 10'd0;
        cur_mult = 8'd0;
        stop     = 1'b0;
        for (int t = 0; t < TIMES_PER_CODE; t++)
        begin
            if (!stop && mults[8*t +: 8] != 8'd0)
            begin
                len  = len + 3'd1;
                msum = msum + {2'b0, mults[8*t +: 8]};
            end
            else
            begin
                stop = 1'b1;
            end
            if (prog_reg == 3'(t))
            begin
                cur_mult = mults[8*t +: 8];
            end
        end
    end

    // |dur - nom| * 100 <= nom * tol  is the inclusive window test
    always_comb
    begin
        if ({8'b0, dur_reg} > nom_reg)
            diff = {8'b0, dur_reg} - nom_reg;
        else
            diff = nom_reg - {8'b0, dur_reg};
        lhs = {7'b0, diff} * {24'b0, ptcd_pkg::PCT_SCALE};
        rhs = {7'b0, nom_reg} * {24'b0, tolerance_pct};
    end

    always_comb
    begin
        cmp = (phase_reg == ptcd_pkg::PH_CMP);
        if (frame_count == 7'd0)
            start_ok = kind[ptcd_pkg::KB_START];
        else
            start_ok = kind[ptcd_pkg::KB_DATA] | kind[ptcd_pkg::KB_END];
        chk      = cmp && alive_reg && (len != 3'd0) && start_ok;
        hit      = chk && (prog_reg < len) && (lhs <= rhs);
        retry    = chk && !hit && (prog_reg == 3'd1) && (frame_count == 7'd0);
        complete = hit && ((prog_reg + 3'd1) == len);
    end

    always_comb
    begin
        case (phase_reg)
            ptcd_pkg::PH_IDLE: phase_next = hand_in.valid ? ptcd_pkg::PH_NOM : ptcd_pkg::PH_IDLE;
            ptcd_pkg::PH_NOM:  phase_next = ptcd_pkg::PH_CMP;
            ptcd_pkg::PH_CMP:  phase_next = retry ? ptcd_pkg::PH_NOM : ptcd_pkg::PH_IDLE;
            default:           phase_next = ptcd_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ptcd_pkg::PH_IDLE;
            alive_reg      <= 1'b1;
            prog_reg       <= 3'd0;
            sum_reg        <= 19'd0;
            hand_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hand_valid_reg <= cmp && !retry && !complete;
            if (clr)
            begin
                alive_reg <= 1'b1;
                prog_reg  <= 3'd0;
                sum_reg   <= 19'd0;
            end
            else if (cmp && alive_reg)
            begin
                alive_reg <= hit;
                if (hit)
                begin
                    prog_reg <= prog_reg + 3'd1;
                    sum_reg  <= sum_reg + {3'b0, dur_reg};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == ptcd_pkg::PH_IDLE && hand_in.valid)
        begin
            dur_reg <= hand_in.dur;
            any_reg <= hand_in.hit_any;
        end
        if (phase_reg == ptcd_pkg::PH_NOM)
            nom_reg <= {8'b0, active_base} * {16'b0, cur_mult};
        hand_dur_reg <= dur_reg;
        hand_any_reg <= any_reg | hit;
    end

    // status is zero outside the compare phase so the top level can OR the cells
    assign hand_out.valid   = hand_valid_reg;
    assign hand_out.dur     = hand_dur_reg;
    assign hand_out.hit_any = hand_any_reg;
    assign status.complete  = complete;
    assign status.retry     = retry;
    assign status.kind      = cmp ? kind : 3'd0;
    assign status.idx       = cmp ? 3'(IDX) : 3'd0;
    assign status.sum       = cmp ? (sum_reg + {3'b0, dur_reg}) : 19'd0;
    assign status.msum      = cmp ? msum : 10'd0;

    a_nom_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ptcd_pkg::PH_NOM |=> phase_reg == ptcd_pkg::PH_CMP)
        else $error("cell skipped compare phase");
    a_complete_stops: assert property (@(posedge clk) disable iff (!rst_n)
        complete |=> !hand_valid_reg)
        else $error("walk continued past a completed code");
    a_retry_reruns: assert property (@(posedge clk) disable iff (!rst_n)
        retry |=> (phase_reg == ptcd_pkg::PH_NOM && prog_reg == 3'd0))
        else $error("retry did not restart the cell");

endmodule

// ===== rtl/ptcd_ctrl.sv =====
// Frame controller: config registers, frame count, base time, divider, result queue.
// Depends on ptcd_pkg.
module ptcd_ctrl #(
    parameter int MAX_FRAME = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [3:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ptcd_pkg::ptcd_status_t status,
    input  ptcd_pkg::ptcd_hand_t   last_hand,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             event_res,
    output logic [2:0]             code_index,
    output logic [6:0]             frame_length,
    output logic                   clr,
    output logic [6:0]             frame_count,
    output logic [15:0]            active_base,
    output logic [6:0]             tolerance_pct,
    output logic [17:0]            code_kinds,
    output logic [191:0]           mult_words
);

    localparam logic [6:0] MAX_FRAME_L = 7'(MAX_FRAME);

    ptcd_pkg::ctrl_state_t state_reg, state_next;
    logic [15:0] base_time_reg;
    logic [6:0]  tol_reg, minf_reg, maxf_reg;
    logic [17:0] kinds_reg;
    logic [63:0] mult_a_reg, mult_b_reg, mult_c_reg;
    logic [6:0]  fc_reg;
    logic [15:0] base_reg;

    logic        pend_valid_reg;
    logic [1:0]  pend_ev_reg;
    logic [2:0]  pend_idx_reg;
    logic [6:0]  pend_len_reg;
    logic        out_valid_reg;
    logic [1:0]  out_ev_reg;
    logic [2:0]  out_idx_reg;
    logic [6:0]  out_len_reg;

    logic [9:0]  rem_reg;
    logic [18:0] quo_reg;
    logic [9:0]  dvs_reg;
    logic [4:0]  cnt_reg;

    logic        run, nomatch, accept;
    logic [6:0]  fc_new, limit;
    logic [1:0]  ev;
    logic [10:0] trial;
    logic        ge;

    always_comb
    begin
        run     = (state_reg == ptcd_pkg::CT_RUN);
        nomatch = run && last_hand.valid && !last_hand.hit_any;
        accept  = in_valid && !in_stall;
        fc_new  = fc_reg + 7'd1;
        limit   = (maxf_reg < MAX_FRAME_L) ? maxf_reg : MAX_FRAME_L;
        if (status.kind == ptcd_pkg::KIND_END_ONLY && fc_new < minf_reg)
            ev = ptcd_pkg::EV_SHORT;
        else if (status.kind[ptcd_pkg::KB_END] && fc_new >= minf_reg)
            ev = ptcd_pkg::EV_DONE;
        else if (fc_new >= limit)
            ev = ptcd_pkg::EV_DONE;
        else
            ev = ptcd_pkg::EV_ADD;
        trial = {rem_reg, quo_reg[18]};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // next state
    always_comb
    begin
        case (state_reg)
            ptcd_pkg::CT_IDLE:
                state_next = accept ? ptcd_pkg::CT_RUN : ptcd_pkg::CT_IDLE;
            ptcd_pkg::CT_RUN:
            begin
                if (status.complete)
                    state_next = (ev == ptcd_pkg::EV_ADD && fc_reg == 7'd0)
                                 ? ptcd_pkg::CT_DIV : ptcd_pkg::CT_IDLE;
                else if (last_hand.valid)
                    state_next = ptcd_pkg::CT_IDLE;
                else
                    state_next = ptcd_pkg::CT_RUN;
            end
            ptcd_pkg::CT_DIV:
                state_next = (cnt_reg == 5'd0) ? ptcd_pkg::CT_IDLE : ptcd_pkg::CT_DIV;
            default:
                state_next = ptcd_pkg::CT_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_stall = (state_reg != ptcd_pkg::CT_IDLE) || pend_valid_reg;
        clr      = run && (status.complete || status.retry || nomatch);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptcd_pkg::CT_IDLE;
            base_time_reg  <= ptcd_pkg::RST_BASE_TIME;
            tol_reg        <= ptcd_pkg::RST_TOLERANCE;
            minf_reg       <= ptcd_pkg::RST_MIN_FRAME;
            maxf_reg       <= ptcd_pkg::RST_MAX_FRAME;
            kinds_reg      <= 18'd0;
            mult_a_reg     <= 64'd0;
            mult_b_reg     <= 64'd0;
            mult_c_reg     <= 64'd0;
            fc_reg         <= 7'd0;
            base_reg       <= ptcd_pkg::RST_BASE_TIME;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ptcd_pkg::REG_BASE_TIME: base_time_reg <= cfg_data[15:0];
                    ptcd_pkg::REG_TOLERANCE: tol_reg       <= cfg_data[6:0];
                    ptcd_pkg::REG_MIN_FRAME: minf_reg      <= cfg_data[6:0];
                    ptcd_pkg::REG_MAX_FRAME: maxf_reg      <= cfg_data[6:0];
                    ptcd_pkg::REG_KINDS:     kinds_reg     <= cfg_data[17:0];
                    ptcd_pkg::REG_MULT_A:    mult_a_reg    <= cfg_data;
                    ptcd_pkg::REG_MULT_B:    mult_b_reg    <= cfg_data;
                    ptcd_pkg::REG_MULT_C:    mult_c_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (run && status.complete)
            begin
                pend_valid_reg <= 1'b1;
                if (ev != ptcd_pkg::EV_ADD)
                begin
                    fc_reg   <= 7'd0;
                    base_reg <= base_time_reg;
                end
                else
                begin
                    fc_reg <= fc_new;
                end
            end
            else if (run && status.retry)
            begin
                fc_reg   <= 7'd0;
                base_reg <= base_time_reg;
            end
            else if (nomatch)
            begin
                fc_reg   <= 7'd0;
                base_reg <= base_time_reg;
                if (fc_reg != 7'd0)
                    pend_valid_reg <= 1'b1;
            end
            else if (state_reg == ptcd_pkg::CT_DIV && cnt_reg == 5'd0)
            begin
                base_reg <= (|quo_reg[17:15]) ? 16'hFFFF : {quo_reg[14:0], ge};
            end

            // result queue: pending slot feeds the output register
            if (pend_valid_reg && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: pending result, output register, divider datapath
    always_ff @(posedge clk)
    begin
        if (run && status.complete)
        begin
            pend_ev_reg  <= ev;
            pend_idx_reg <= status.idx;
            pend_len_reg <= fc_new;
            rem_reg      <= 10'd0;
            quo_reg      <= status.sum;
            dvs_reg      <= status.msum;
            cnt_reg      <= 5'd18;
        end
        else if (nomatch)
        begin
            pend_ev_reg  <= ptcd_pkg::EV_ABANDON;
            pend_idx_reg <= 3'd0;
            pend_len_reg <= 7'd0;
        end
        else if (state_reg == ptcd_pkg::CT_DIV)
        begin
            rem_reg <= ge ? 10'(trial - {1'b0, dvs_reg}) : trial[9:0];
            quo_reg <= {quo_reg[17:0], ge};
            cnt_reg <= cnt_reg - 5'd1;
        end
        if (pend_valid_reg && (!out_valid_reg || !out_stall))
        begin
            out_ev_reg  <= pend_ev_reg;
            out_idx_reg <= pend_idx_reg;
            out_len_reg <= pend_len_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign event_res     = out_ev_reg;
    assign code_index    = out_idx_reg;
    assign frame_length  = out_len_reg;
    assign frame_count   = fc_reg;
    assign active_base   = base_reg;
    assign tolerance_pct = tol_reg;
    assign code_kinds    = kinds_reg;
    assign mult_words    = {mult_c_reg, mult_b_reg, mult_a_reg};

endmodule
